[src/efsd_pkg.sv]
// Shared types, constants and helpers for the earliest-free server dispatch block.
// Depends on nothing; every other file imports it.
package efsd_pkg;

    localparam int MAX_SERVERS = 16;
    localparam int SRV_IDX_W   = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CNT_W       = $clog2(MAX_SERVERS + 1);
    localparam int SRV_NUM_W   = 5;
    localparam int TIME_W      = 32;
    localparam int DUR_W       = 16;

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam logic REG_NUM_SERVERS = 1'b0;
    localparam logic [SRV_NUM_W-1:0] NUM_SERVERS_RST = 5'd16;

    typedef struct packed {
        logic             batch_start;
        logic [DUR_W-1:0] duration;
    } job_word_t;

    typedef struct packed {
        logic [SRV_NUM_W-1:0] server;
        logic [TIME_W-1:0]    start_time;
        logic [SRV_NUM_W-1:0] next_server;
    } res_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
        logic res_free;
    } dp_stat_t;

    // Clamp the register value into 1..MAX_SERVERS.
    function automatic logic [CNT_W-1:0] active_count(input logic [SRV_NUM_W-1:0] num);
        logic [CNT_W-1:0] n;
        if (num == '0) begin
            n = CNT_W'(1);
        end
        else if (int'(num) > MAX_SERVERS) begin
            n = CNT_W'(MAX_SERVERS);
        end
        else begin
            n = CNT_W'(num);
        end
        return n;
    endfunction

    // Server numbers count from 1.
    function automatic logic [SRV_NUM_W-1:0] srv_number(input logic [SRV_IDX_W-1:0] idx);
        logic [SRV_IDX_W:0] t;
        t = {1'b0, idx} + 1'b1;
        return SRV_NUM_W'(t);
    endfunction

endpackage

[src/efsd_ctrl.sv]
// Controller state machine of the dispatch block: sequences load, scan and commit.
// Depends on efsd_pkg.
module efsd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_ready,
    output efsd_pkg::dp_cmd_t cmd,
    input  efsd_pkg::dp_stat_t stat
);
    import efsd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        job_ready  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                job_ready = 1'b1;
                cmd.load  = job_valid;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_DONE:
            begin
                cmd.commit = stat.res_free;
            end
            default:
            begin
                job_ready = 1'b0;
            end
        endcase
    end

endmodule

[src/efsd_dp.sv]
// Datapath of the dispatch block: finish-time registers, min/second-min scan,
// saturating update and the result register. Depends on efsd_pkg.
module efsd_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  efsd_pkg::dp_cmd_t              cmd,
    output efsd_pkg::dp_stat_t             stat,
    input  efsd_pkg::job_word_t            job,
    input  logic [efsd_pkg::CNT_W-1:0]     n_active,
    output logic                           res_valid,
    input  logic                           res_ready,
    output efsd_pkg::res_word_t            res
);
    import efsd_pkg::*;

    logic [TIME_W-1:0]    ft_reg [MAX_SERVERS];
    logic [SRV_IDX_W-1:0] scan_idx_reg;
    logic [SRV_IDX_W-1:0] scan_idx_next;
    logic [SRV_IDX_W-1:0] last_idx_reg;
    logic [DUR_W-1:0]     dur_reg;

    logic [SRV_IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [TIME_W-1:0]    best_val_reg, best_val_next;
    logic [SRV_IDX_W-1:0] sec_idx_reg, sec_idx_next;
    logic [TIME_W-1:0]    sec_val_reg, sec_val_next;
    logic                 sec_vld_reg, sec_vld_next;

    logic                 res_valid_reg;
    res_word_t            res_reg;

    logic [TIME_W-1:0]    rd_val;
    logic [TIME_W:0]      sum_wide;
    logic [TIME_W-1:0]    sum_sat;
    logic [SRV_IDX_W-1:0] next_idx;
    logic [CNT_W-1:0]     n_minus_1;

    assign rd_val    = ft_reg[scan_idx_reg];
    assign n_minus_1 = n_active - 1'b1;

    assign stat.scan_last = (scan_idx_reg == last_idx_reg);
    assign stat.res_free  = !res_valid_reg || res_ready;

    // Track smallest and second smallest; strict compares keep the lowest index on ties.
    always_comb
    begin
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        sec_idx_next  = sec_idx_reg;
        sec_val_next  = sec_val_reg;
        sec_vld_next  = sec_vld_reg;
        scan_idx_next = scan_idx_reg;
        if (cmd.load)
        begin
            scan_idx_next = '0;
        end
        else if (cmd.scan)
        begin
            scan_idx_next = scan_idx_reg + 1'b1;
            priority if (scan_idx_reg == '0)
            begin
                best_idx_next = scan_idx_reg;
                best_val_next = rd_val;
                sec_vld_next  = 1'b0;
            end
            else if (rd_val < best_val_reg)
            begin
                sec_idx_next  = best_idx_reg;
                sec_val_next  = best_val_reg;
                sec_vld_next  = 1'b1;
                best_idx_next = scan_idx_reg;
                best_val_next = rd_val;
            end
            else if (!sec_vld_reg || (rd_val < sec_val_reg))
            begin
                sec_idx_next  = scan_idx_reg;
                sec_val_next  = rd_val;
                sec_vld_next  = 1'b1;
            end
            else
            begin
                sec_vld_next = sec_vld_reg;
            end
        end
    end

    assign sum_wide = {1'b0, best_val_reg} + {{(TIME_W + 1 - DUR_W){1'b0}}, dur_reg};
    assign sum_sat  = sum_wide[TIME_W] ? {TIME_W{1'b1}} : sum_wide[TIME_W-1:0];

    // Next pick after the update: the chosen server with its new time against the runner-up.
    always_comb
    begin
        priority if (!sec_vld_reg)
        begin
            next_idx = best_idx_reg;
        end
        else if (sum_sat < sec_val_reg)
        begin
            next_idx = best_idx_reg;
        end
        else if ((sum_sat == sec_val_reg) && (best_idx_reg < sec_idx_reg))
        begin
            next_idx = best_idx_reg;
        end
        else
        begin
            next_idx = sec_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_SERVERS; k++)
            begin
                ft_reg[k] <= '0;
            end
            scan_idx_reg  <= '0;
            sec_vld_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < MAX_SERVERS; k++)
            begin
                if (cmd.load && job.batch_start)
                begin
                    ft_reg[k] <= '0;
                end
                else if (cmd.commit && (best_idx_reg == SRV_IDX_W'(k)))
                begin
                    ft_reg[k] <= sum_sat;
                end
            end
            scan_idx_reg <= scan_idx_next;
            sec_vld_reg  <= sec_vld_next;
            if (cmd.commit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dur_reg      <= job.duration;
            last_idx_reg <= SRV_IDX_W'(n_minus_1);
        end
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        sec_idx_reg  <= sec_idx_next;
        sec_val_reg  <= sec_val_next;
        if (cmd.commit)
        begin
            res_reg.server      <= srv_number(best_idx_reg);
            res_reg.start_time  <= best_val_reg;
            res_reg.next_server <= srv_number(next_idx);
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

[src/earliest_free_server_dispatch_top.sv]
// Top level of the earliest-free server dispatch block: APB register, controller
// and datapath. Depends on efsd_pkg, efsd_ctrl and efsd_dp.
//
//  channel   signals                               word / register
//  -------   -----------------------------------   ------------------------------------
//  job       job_valid, job_ready, job              job_word_t {batch_start, duration}
//  result    res_valid, res_ready, res              res_word_t {server, start_time,
//                                                               next_server}
//  config    psel penable pwrite paddr pwdata ...   num_servers at byte address 0
//
// Steps: a job runs through these in order, n being the active server count (1..16):
//   taking the word (and clearing all finish times on batch_start), walking
//   the finish-time registers of the n servers one server per cycle, and
//   writing the updated finish time and loading the result register.
// Reset: rst_n clears every finish time and sets num_servers to 16.
// Stalls: a result waiting in the output register does not block the next job
//   word; only the commit cycle waits until the result register is free.
module earliest_free_server_dispatch_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // job channel
    input  logic                                job_valid,
    output logic                                job_ready,
    input  efsd_pkg::job_word_t                 job,
    // result channel
    output logic                                res_valid,
    input  logic                                res_ready,
    output efsd_pkg::res_word_t                 res,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [efsd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [efsd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [efsd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import efsd_pkg::*;

    logic [SRV_NUM_W-1:0] num_servers_reg;
    logic [CNT_W-1:0]     n_active;
    logic                 reg_sel;
    dp_cmd_t              cmd;
    dp_stat_t             stat;

    // Register index is the word address; index 1 and up hit nothing.
    assign reg_sel = (paddr[2] == REG_NUM_SERVERS);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_servers_reg <= NUM_SERVERS_RST;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            num_servers_reg <= pwdata[SRV_NUM_W-1:0];
        end
    end

    // Read back the raw register value; unmapped addresses read zero.
    assign prdata = reg_sel ? {{(APB_DATA_W - SRV_NUM_W){1'b0}}, num_servers_reg} : '0;

    // Clamp to 1..MAX_SERVERS; the datapath latches it when a job is taken.
    assign n_active = active_count(num_servers_reg);

    efsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    efsd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .job       (job),
        .n_active  (n_active),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

[src/efsd_chk.sv]
// Port-level checker for the dispatch block, bound to the top level.
// Depends on efsd_pkg and earliest_free_server_dispatch_top.
module efsd_chk (
    input logic                clk,
    input logic                rst_n,
    input logic                job_valid,
    input logic                job_ready,
    input efsd_pkg::job_word_t job,
    input logic                res_valid,
    input logic                res_ready,
    input efsd_pkg::res_word_t res
);
    import efsd_pkg::*;

    // Hold a stalled result word.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result word dropped or changed while stalled");

    // One job at a time: job_ready stays low after a word is taken.
    a_job_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && job_ready |=> !job_ready ##1 !job_ready)
        else $error("job word taken while another is in flight");

    // Server numbers count from 1 and never exceed MAX_SERVERS.
    a_srv_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.server != '0) && (int'(res.server) <= MAX_SERVERS)
                   && (res.next_server != '0) && (int'(res.next_server) <= MAX_SERVERS))
        else $error("server number out of range");

    // A fresh result word comes from a commit, and a commit happens only while
    // the job channel is closed.
    a_res_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(!job_ready))
        else $error("result appeared while the block was idle");

endmodule

bind earliest_free_server_dispatch_top efsd_chk u_efsd_chk (.*);
